// ----- src/qmr_pkg.sv -----
// shared types, constants and helpers for the quaternion multiply unit
package qmr_pkg;

	localparam int FRAC_BITS      = 14;
	localparam int SQRT_EXTRA     = 14;
	localparam int COMP_W         = 16;
	localparam int PROD_W         = 2 * COMP_W;
	localparam int ACC_W          = PROD_W + 3;
	localparam int MAG_W          = 2 * COMP_W + 1;
	localparam int RAD_W          = 2 * (MAG_W + 2 * SQRT_EXTRA + 1) / 2;
	localparam int ROOT_W         = RAD_W / 2;
	localparam int DIVD_W         = COMP_W + FRAC_BITS + SQRT_EXTRA + 2;
	localparam int DIVS_W         = ROOT_W + 1;
	localparam int QUO_W          = FRAC_BITS + 3;
	localparam int PERIOD_W       = 4;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 4'd10;

	// register map, indexed by byte address bit 2
	localparam logic REG_RENORM_PERIOD = 1'b0;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// one multiply term: operand selects and whether it is subtracted
	typedef struct packed {
		logic [2:0] sel_a;
		logic [2:0] sel_b;
		logic       neg;
	} term_t;

	// command from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic  en;
		logic  clr;
		logic  neg;
		comp_t a;
		comp_t b;
	} mac_cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_SAVE,
		ST_SQ_ISSUE,
		ST_SQ_DRAIN,
		ST_SQ_CHECK,
		ST_SQRT,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_FINISH
	} state_t;

	// operand codes: q1 x,y,z,w then q2 x,y,z,w
	localparam logic [2:0] OP_AX = 3'd0;
	localparam logic [2:0] OP_AY = 3'd1;
	localparam logic [2:0] OP_AZ = 3'd2;
	localparam logic [2:0] OP_AW = 3'd3;
	localparam logic [2:0] OP_BX = 3'd4;
	localparam logic [2:0] OP_BY = 3'd5;
	localparam logic [2:0] OP_BZ = 3'd6;
	localparam logic [2:0] OP_BW = 3'd7;

	// term schedule: component in the upper two bits, term in the lower two
	function automatic term_t term_of(input logic [3:0] idx);
		term_t t;
		case (idx)
			4'd0:  t = '{OP_AX, OP_BW, 1'b0};
			4'd1:  t = '{OP_BX, OP_AW, 1'b0};
			4'd2:  t = '{OP_BY, OP_AZ, 1'b0};
			4'd3:  t = '{OP_BZ, OP_AY, 1'b1};
			4'd4:  t = '{OP_AY, OP_BW, 1'b0};
			4'd5:  t = '{OP_BY, OP_AW, 1'b0};
			4'd6:  t = '{OP_BZ, OP_AX, 1'b0};
			4'd7:  t = '{OP_BX, OP_AZ, 1'b1};
			4'd8:  t = '{OP_AZ, OP_BW, 1'b0};
			4'd9:  t = '{OP_BZ, OP_AW, 1'b0};
			4'd10: t = '{OP_BX, OP_AY, 1'b0};
			4'd11: t = '{OP_BY, OP_AX, 1'b1};
			4'd12: t = '{OP_AW, OP_BW, 1'b0};
			4'd13: t = '{OP_AX, OP_BX, 1'b1};
			4'd14: t = '{OP_AY, OP_BY, 1'b1};
			4'd15: t = '{OP_AZ, OP_BZ, 1'b1};
			default: t = '{OP_AX, OP_BX, 1'b0};
		endcase
		return t;
	endfunction

	// round to nearest with ties up, then saturate to 16 bits
	function automatic comp_t round_sat(input acc_t s);
		logic signed [ACC_W:0] b;
		logic signed [ACC_W:0] t;
		b = {s[ACC_W-1], s} + (ACC_W+1)'(1 << (FRAC_BITS - 1));
		t = b >>> FRAC_BITS;
		if (t > (ACC_W+1)'(32767))
			return comp_t'(16'sd32767);
		else if (t < -(ACC_W+1)'(32768))
			return comp_t'(-16'sd32768);
		else
			return comp_t'(t[COMP_W-1:0]);
	endfunction

endpackage

// ----- src/qmr_mac.sv -----
// shared multiply-accumulate unit: registered product, then accumulate
module qmr_mac
	import qmr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mac_cmd_t cmd,
	output acc_t     acc
);

	logic signed [PROD_W-1:0] prod_s1;
	logic                     en_s1;
	logic                     clr_s1;
	logic                     neg_s1;
	acc_t                     acc_q;
	acc_t                     prod_ext;

	// product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
		end else begin
			en_s1 <= cmd.en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= cmd.a * cmd.b;
		clr_s1  <= cmd.clr;
		neg_s1  <= cmd.neg;
	end

	assign prod_ext = ACC_W'(prod_s1);

	// accumulate stage
	always_ff @(posedge clk) begin
		if (en_s1) begin
			if (clr_s1)
				acc_q <= neg_s1 ? -prod_ext : prod_ext;
			else
				acc_q <= neg_s1 ? acc_q - prod_ext : acc_q + prod_ext;
		end
	end

	assign acc = acc_q;

endmodule

// ----- src/qmr_sqrt.sv -----
// integer square root, two radicand bits per cycle
module qmr_sqrt
	import qmr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [RAD_W-1:0]  radicand,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 4;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [REM_W-1:0]  rem_x;
	logic [REM_W-1:0]  trial;
	logic              fits;

	// one digit step
	always_comb begin
		rem_x = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial = {2'b00, root_q, 2'b01};
		fits  = rem_x >= trial;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? rem_x - trial : rem_x;
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ----- src/qmr_div.sv -----
// restoring divider, one quotient bit per cycle
module qmr_div
	import qmr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic              done,
	output logic [QUO_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(QUO_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] dsr_q;
	logic [QUO_W-1:0]  low_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DIVS_W:0]   rem_x;
	logic              fits;

	// trial subtract
	always_comb begin
		rem_x = {rem_q, low_q[QUO_W-1]};
		fits  = rem_x >= {1'b0, dsr_q};
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: upper dividend bits are known to stay below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIVS_W'(dividend[DIVD_W-1:QUO_W]);
			low_q <= dividend[QUO_W-1:0];
			dsr_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIVS_W'(rem_x - {1'b0, dsr_q}) : DIVS_W'(rem_x);
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/quaternion_multiply_renormalize_unit.sv -----
// top level: sequencer, operand capture, result register and config port
//
// Multiplies two Q2.14 quaternions and every few products scales the result
// to unit length.
// Input stream s_axis: one transaction carries q1 and q2 (eight components).
// Output stream m_axis: one transaction per input, the four product components
// in tdata and the renormalized flag in tuser.
// Config: APB register renorm_period at address 0 (reset value 10). A result is
// renormalized when the incremented call count exceeds the period.
// All sixteen products and the four squares go through one 16x16 multiplier
// with an accumulator. A plain product passes through the four component
// sums into the output register; a renormalized product adds the square
// pass, the square root and four divides. One item is in work at a time;
// s_axis_tready is high only while the sequencer is idle, so a new item is
// taken only once the last one has gone to the output register.
// The result sits in an output register; if the receiver stalls, the next
// item may be accepted and computed, then waits until the register frees.
// Reset clears the sequencer, the call counter and the output valid, and
// loads the period with 10.
module quaternion_multiply_renormalize_unit
	import qmr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	// q1_x, q1_y, q1_z, q1_w, q2_x, q2_y, q2_z, q2_w from bit 0 up
	input  logic [127:0] s_axis_tdata,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// out_x, out_y, out_z, out_w from bit 0 up
	output logic [63:0]  m_axis_tdata,
	// was_normalized
	output logic [0:0]   m_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	state_t                state_q, state_d;
	logic [PERIOD_W-1:0]   period_q;
	logic [PERIOD_W-1:0]   count_q;
	logic                  norm_req_q;
	logic                  norm_done_q;
	comp_t                 op_q [8];
	comp_t                 comp_q [4];
	logic [1:0]            ci_q;
	logic [1:0]            k_q;
	logic [63:0]           out_data_q;
	logic                  out_user_q;
	logic                  out_valid_q;

	mac_cmd_t              mac_cmd;
	acc_t                  acc;
	term_t                 term;
	logic                  sqrt_start;
	logic                  sqrt_done;
	logic [ROOT_W-1:0]     root;
	logic                  div_start;
	logic                  div_done;
	logic [QUO_W-1:0]      quotient;
	logic [DIVD_W-1:0]     dividend;
	logic [COMP_W-1:0]     cur_mag;
	comp_t                 scaled;
	logic [PERIOD_W:0]     count_next;
	logic                  in_xact;
	logic                  out_free;
	logic                  cfg_wr;

	assign in_xact    = s_axis_tvalid && s_axis_tready;
	assign out_free   = !out_valid_q || m_axis_tready;
	assign count_next = {1'b0, count_q} + 1'b1;
	assign term       = term_of({ci_q, k_q});

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RENORM_PERIOD);
	assign prdata = (paddr[2] == REG_RENORM_PERIOD) ? {28'd0, period_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (cfg_wr) begin
			period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	// call counter, advanced when an item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			norm_req_q <= 1'b0;
		end else if (in_xact) begin
			norm_req_q <= count_next > {1'b0, period_q};
			count_q    <= (count_next > {1'b0, period_q}) ? '0 : count_next[PERIOD_W-1:0];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider operands for the current component
	assign cur_mag  = comp_q[ci_q][COMP_W-1] ? COMP_W'(-comp_q[ci_q]) : comp_q[ci_q];
	assign dividend = {cur_mag, {(FRAC_BITS + SQRT_EXTRA + 1){1'b0}}} + DIVD_W'(root);

	// scaled component with sign restored and saturation
	always_comb begin
		if (comp_q[ci_q][COMP_W-1])
			scaled = (quotient >= QUO_W'(32768)) ? comp_t'(-16'sd32768)
				: comp_t'(-$signed({1'b0, quotient[COMP_W-2:0]}));
		else
			scaled = (quotient > QUO_W'(32767)) ? comp_t'(16'sd32767)
				: comp_t'({1'b0, quotient[COMP_W-2:0]});
	end

	// next state and unit commands
	always_comb begin
		state_d     = state_q;
		mac_cmd     = '0;
		sqrt_start  = 1'b0;
		div_start   = 1'b0;
		s_axis_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				mac_cmd = '{1'b1, k_q == 2'd0, term.neg, op_q[term.sel_a], op_q[term.sel_b]};
				if (k_q == 2'd3)
					state_d = ST_DRAIN;
			end
			ST_DRAIN: state_d = ST_SAVE;
			ST_SAVE: begin
				if (ci_q == 2'd3)
					state_d = norm_req_q ? ST_SQ_ISSUE : ST_FINISH;
				else
					state_d = ST_ISSUE;
			end
			ST_SQ_ISSUE: begin
				mac_cmd = '{1'b1, ci_q == 2'd0, 1'b0, comp_q[ci_q], comp_q[ci_q]};
				if (ci_q == 2'd3)
					state_d = ST_SQ_DRAIN;
			end
			ST_SQ_DRAIN: state_d = ST_SQ_CHECK;
			ST_SQ_CHECK: begin
				if (acc == '0) begin
					state_d = ST_FINISH;
				end else begin
					sqrt_start = 1'b1;
					state_d    = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sqrt_done)
					state_d = ST_DIV_START;
			end
			ST_DIV_START: begin
				div_start = 1'b1;
				state_d   = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (div_done)
					state_d = (ci_q == 2'd3) ? ST_FINISH : ST_DIV_START;
			end
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencing counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ci_q        <= '0;
			k_q         <= '0;
			norm_done_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					ci_q        <= '0;
					k_q         <= '0;
					norm_done_q <= 1'b0;
				end
				ST_ISSUE:    k_q  <= k_q + 1'b1;
				ST_SAVE:     ci_q <= ci_q + 1'b1;
				ST_SQ_ISSUE: ci_q <= ci_q + 1'b1;
				ST_SQ_CHECK: norm_done_q <= acc != '0;
				ST_DIV_RUN: begin
					if (div_done)
						ci_q <= ci_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// operand capture and component store
	always_ff @(posedge clk) begin
		if (in_xact) begin
			for (int i = 0; i < 8; i++)
				op_q[i] <= s_axis_tdata[i*COMP_W +: COMP_W];
		end
		if (state_q == ST_SAVE)
			comp_q[ci_q] <= round_sat(acc);
		if (state_q == ST_DIV_RUN && div_done)
			comp_q[ci_q] <= scaled;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			out_data_q <= {comp_q[3], comp_q[2], comp_q[1], comp_q[0]};
			out_user_q <= norm_done_q;
		end
	end

	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tvalid = out_valid_q;

	qmr_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.acc    (acc)
	);

	qmr_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand ({acc[MAG_W-1:0], {(RAD_W - MAG_W){1'b0}}} >> 1),
		.done     (sqrt_done),
		.root     (root)
	);

	qmr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  ({root, 1'b0}),
		.done     (div_done),
		.quotient (quotient)
	);

endmodule

// ----- src/qmr_checker.sv -----
// port-level checks for the quaternion multiply unit
module qmr_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [63:0]  m_axis_tdata,
	input logic [0:0]   m_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic         pready
);

	// a taken item keeps the block busy for the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while previous item still in work");

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("stalled result changed");

	// a renormalized result cannot be all zero
	a_norm_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata != 64'd0)
		else $error("renormalized result is zero");

	// config port never waits
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind quaternion_multiply_renormalize_unit qmr_checker u_qmr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.pready        (pready)
);
